/* src/u8l1_pkg.sv */
`default_nettype none
package u8l1_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int WIN_DEPTH       = 4;

  localparam logic [7:0] LAT_HI    = 8'hC0;
  localparam logic [7:0] LAT_LO    = 8'h80;
  localparam logic [7:0] LOW6_MASK = 8'h3F;

  // one input byte with its class, as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ascii;
    logic       lead;
    logic [1:0] need;   // continuation bytes a lead byte asks for
    logic       cont;
  } qent_t;

endpackage
`default_nettype wire

/* src/u8l1_front.sv */
`default_nettype none
module u8l1_front
  import u8l1_pkg::*;
(
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,
  input  wire logic       s_axis_tlast,
  output      logic       push_valid,
  input  wire logic       push_ready,
  output      qent_t      push_data
);

  logic lead2, lead3, lead4;

  always_comb begin
    lead2 = s_axis_tdata[7:5] == 3'b110;
    lead3 = s_axis_tdata[7:4] == 4'b1110;
    lead4 = s_axis_tdata[7:3] == 5'b11110;

    push_data.data  = s_axis_tdata;
    push_data.last  = s_axis_tlast;
    push_data.ascii = ~s_axis_tdata[7];
    push_data.cont  = s_axis_tdata[7:6] == 2'b10;
    push_data.lead  = lead2 | lead3 | lead4;
    if (lead2) begin
      push_data.need = 2'd1;
    end else if (lead3) begin
      push_data.need = 2'd2;
    end else if (lead4) begin
      push_data.need = 2'd3;
    end else begin
      push_data.need = 2'd0;
    end
  end

  assign push_valid    = s_axis_tvalid;
  assign s_axis_tready = push_ready;

endmodule
`default_nettype wire

/* src/u8l1_fifo.sv */
`default_nettype none
module u8l1_fifo
  import u8l1_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output      logic  push_ready,
  input  wire qent_t push_data,
  output      logic  pop_valid,
  input  wire logic  pop_ready,
  output      qent_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t           mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push, pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* src/u8l1_back.sv */
`default_nettype none
module u8l1_back
  import u8l1_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       pop_valid,
  output      logic       pop_ready,
  input  wire qent_t      pop_data,
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,
  output      logic       m_axis_tlast,
  output      logic       m_axis_tuser
);

  qent_t       win [WIN_DEPTH];
  qent_t       win_next [WIN_DEPTH];
  logic [2:0]  cnt;
  logic [2:0]  cnt_sh;
  logic        flushing;
  logic        busy, busy_next;
  logic        lat, lat_next;
  logic        dflush, dflush_next;
  logic [1:0]  rem, rem_next;

  logic        start, oready, fire, shift, last, dfl, load;
  logic        c1, c2, c3;
  logic [2:0]  len;
  logic [7:0]  ob;
  logic        run_last, done;

  always_comb begin
    start  = !busy && (cnt == 3'd4 || (flushing && cnt != 3'd0));
    c1     = cnt > 3'd1 && win[1].cont;
    c2     = cnt > 3'd2 && win[2].cont;
    c3     = cnt > 3'd3 && win[3].cont;
    if (win[0].ascii) begin
      len = 3'd1;
    end else if (win[0].lead && win[0].need == 2'd1 && c1) begin
      len = 3'd2;
    end else if (win[0].lead && win[0].need == 2'd2 && c1 && c2) begin
      len = 3'd3;
    end else if (win[0].lead && win[0].need == 2'd3 && c1 && c2 && c3) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end

    oready      = !m_axis_tvalid || m_axis_tready;
    fire        = oready && (busy || start);
    shift       = 1'b0;
    last        = 1'b0;
    ob          = win[0].data;
    busy_next   = busy;
    lat_next    = lat;
    rem_next    = rem;
    dflush_next = dflush;
    dfl         = busy ? dflush : flushing;

    if (fire) begin
      if (busy) begin
        if (lat) begin
          ob        = LAT_LO | (win[0].data & LOW6_MASK);
          shift     = 1'b1;
          last      = 1'b1;
          busy_next = 1'b0;
          lat_next  = 1'b0;
        end else begin
          shift     = 1'b1;
          last      = rem == 2'd1;
          rem_next  = rem - 2'd1;
          busy_next = rem != 2'd1;
        end
      end else begin
        dflush_next = flushing;
        if (len == 3'd0) begin
          // latin-1 byte: high half now, low half next beat
          ob        = LAT_HI | {6'b0, win[0].data[7:6]};
          busy_next = 1'b1;
          lat_next  = 1'b1;
        end else begin
          shift     = 1'b1;
          last      = len == 3'd1;
          rem_next  = 2'(len - 3'd1);
          busy_next = len != 3'd1;
          lat_next  = 1'b0;
        end
      end
    end

    cnt_sh   = cnt - {2'b0, shift};
    run_last = last && (!dfl || cnt_sh == 3'd0);
    done     = last && dfl && cnt_sh == 3'd0;
    load     = pop_valid && !flushing && cnt_sh != 3'd4;

    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      if (shift) begin
        win_next[i] = win[i + 1];
      end else begin
        win_next[i] = win[i];
      end
    end
    win_next[WIN_DEPTH - 1] = win[WIN_DEPTH - 1];
    if (load) begin
      win_next[cnt_sh[1:0]] = pop_data;
    end
  end

  assign pop_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      flushing      <= 1'b0;
      busy          <= 1'b0;
      lat           <= 1'b0;
      dflush        <= 1'b0;
      rem           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      cnt    <= cnt_sh + {2'b0, load};
      busy   <= busy_next;
      lat    <= lat_next;
      dflush <= dflush_next;
      rem    <= rem_next;
      if (load && pop_data.last) begin
        flushing <= 1'b1;
      end else if (done) begin
        flushing <= 1'b0;
      end
      if (oready) begin
        m_axis_tvalid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win[i] <= win_next[i];
    end
    if (fire) begin
      m_axis_tdata <= ob;
      m_axis_tlast <= run_last;
      m_axis_tuser <= done;
    end
  end

endmodule
`default_nettype wire

/* src/utf8_latin1_repair_stream.sv */
// channel   dir  tdata (low bit up)  tlast          tuser
// s_axis    in   in_byte[7:0]        end_of_input   -
// m_axis    out  out_byte[7:0]       run_last       stream_done
//
// one output beat per cycle from a single output register while m_axis_tready
// and the window allow; a latin-1 byte goes out as two bytes, others as is.
// input bytes wait in a QUEUE_DEPTH queue, so input and output stall apart.
// a byte with end_of_input holds further input until the window is flushed.
// reset clears the queue, window count and output valid; no clearing pass.
`default_nettype none
module utf8_latin1_repair_stream
  import u8l1_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte
  input  wire logic       s_axis_tlast,
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // out_byte
  output      logic       m_axis_tlast,
  output      logic       m_axis_tuser    // stream_done
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  qent_t push_data, pop_data;

  u8l1_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  u8l1_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  u8l1_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
